>>> hdl/sal_pkg.sv
// Shared types and constants for the shifting array list engine.
// Request/response payload structs, operation and status codes, cell control.
// No dependencies.
package sal_pkg;

    localparam int DATA_W       = 32;
    localparam int POS_W        = 6;
    localparam int OP_W         = 4;
    localparam int COUNT_OUT_W  = 7;
    localparam int CAPACITY_DEF = 64;

    // Operation codes carried in the op field
    typedef enum logic [OP_W-1:0] {
        OP_INSERT     = 4'd0,
        OP_REPLACE    = 4'd1,
        OP_REMOVE     = 4'd2,
        OP_PUSH_FRONT = 4'd3,
        OP_PUSH_BACK  = 4'd4,
        OP_POP_FRONT  = 4'd5,
        OP_POP_BACK   = 4'd6,
        OP_FIND       = 4'd7,
        OP_READ_FRONT = 4'd8,
        OP_READ_BACK  = 4'd9,
        OP_CLEAR      = 4'd10
    } op_t;

    // Result status codes
    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_RANGE    = 3'd1,
        ST_FULL     = 3'd2,
        ST_EMPTY    = 3'd3,
        ST_NOTFOUND = 3'd4
    } status_t;

    // Per-cycle action of the cell row
    typedef enum logic [1:0] {
        CM_HOLD,
        CM_SHIFT_UP,
        CM_WRITE,
        CM_SHIFT_DOWN
    } cell_mode_t;

    typedef struct packed {
        cell_mode_t        mode;
        logic [DATA_W-1:0] data;
    } cell_ctrl_t;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [OP_W-1:0]          op;
        logic [POS_W-1:0]         position;
        logic signed [DATA_W-1:0] data_value;
    } req_t;

    typedef struct packed {
        status_t                  status;
        logic [POS_W-1:0]         found_index;
        logic signed [DATA_W-1:0] read_value;
        logic [COUNT_OUT_W-1:0]   element_count;
    } rsp_t;

endpackage

>>> hdl/sal_cell.sv
// One storage cell of the list: holds a single word at a fixed index.
// Takes its neighbor's word on shifts, or the request word on a write.
// Depends on sal_pkg.
module sal_cell #(
    parameter int IW    = 6,
    parameter int INDEX = 0
) (
    input  logic                      clk,
    input  sal_pkg::cell_ctrl_t       ctrl,
    input  logic [IW-1:0]             pos,
    input  logic [sal_pkg::DATA_W-1:0] below_word,
    input  logic [sal_pkg::DATA_W-1:0] above_word,
    output logic [sal_pkg::DATA_W-1:0] word
);
    import sal_pkg::*;

    localparam logic [IW-1:0] IDX = IW'(INDEX);

    logic [DATA_W-1:0] word_reg;
    logic [DATA_W-1:0] word_next;

    // Next word from the row action and this cell's place relative to pos
    always_comb
    begin
        word_next = word_reg;
        unique case (ctrl.mode)
            CM_HOLD:
            begin
                word_next = word_reg;
            end
            CM_SHIFT_UP:
            begin
                if (IDX > pos)
                    word_next = below_word;
                else if (IDX == pos)
                    word_next = ctrl.data;
            end
            CM_WRITE:
            begin
                if (IDX == pos)
                    word_next = ctrl.data;
            end
            CM_SHIFT_DOWN:
            begin
                if (IDX >= pos)
                    word_next = above_word;
            end
            default:
            begin
                word_next = word_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word = word_reg;

endmodule

>>> hdl/sal_cell_row.sv
// Row of list cells chained by index; the top cell wraps to cell 0 so a
// downward shift from index 0 rotates the whole row. Depends on sal_pkg, sal_cell.
module sal_cell_row #(
    parameter int CAPACITY = 64,
    parameter int IW       = 6
) (
    input  logic                       clk,
    input  sal_pkg::cell_ctrl_t        ctrl,
    input  logic [IW-1:0]              pos,
    output logic [sal_pkg::DATA_W-1:0] head
);
    import sal_pkg::*;

    logic [DATA_W-1:0] words [CAPACITY];

    // Neighbor wiring along the chain
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [DATA_W-1:0] below_w;
        logic [DATA_W-1:0] above_w;

        if (i == 0)
        begin : g_first
            assign below_w = '0;
        end
        else
        begin : g_mid_lo
            assign below_w = words[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign above_w = words[0];
        end
        else
        begin : g_mid_hi
            assign above_w = words[i+1];
        end

        sal_cell #(
            .IW    (IW),
            .INDEX (i)
        ) u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .pos        (pos),
            .below_word (below_w),
            .above_word (above_w),
            .word       (words[i])
        );
    end

    assign head = words[0];

endmodule

>>> hdl/shifting_array_list_engine.sv
// Shifting array list engine: top level with request decode, scan control
// and response register. Depends on sal_pkg, sal_cell_row.
//
// Usage:
//   Requests enter on req/req_valid/req_ready, responses leave on
//   rsp/rsp_valid/rsp_ready; every request gets exactly one response.
//   Insert, replace, remove, push, pop, read front, clear and the flagged
//   cases all finish in the accept cycle: the response is valid the next
//   cycle, one request per cycle while the response side keeps up.
//   Find and read back on a non-empty list rotate the cell row once around
//   through cell 0, which is the only word they look at: the scan state
//   shifts the row down once per cell, then the done state loads the
//   response register. The full turn leaves the list as it was.
//   A new request is taken while a response waits, as long as that response
//   is being taken in the same cycle; a stalled response register holds
//   req_ready low, and a finished scan waits in its own state until the
//   register frees up.
//   Reset empties the list (count zero) and drops any pending response;
//   stored words are not cleared.
module shifting_array_list_engine #(
    parameter int CAPACITY = sal_pkg::CAPACITY_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  sal_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output sal_pkg::rsp_t rsp
);
    import sal_pkg::*;

    localparam int IW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int PW  = (CW > POS_W) ? CW : POS_W;
    localparam int FW  = (IW > POS_W) ? IW : POS_W;
    localparam int OW  = (CW > COUNT_OUT_W) ? CW : COUNT_OUT_W;
    localparam logic [CW-1:0] CAP_CNT  = CW'(CAPACITY);
    localparam logic [IW-1:0] LAST_IDX = IW'(CAPACITY - 1);

    state_t            state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [IW-1:0]     k_reg, k_next;
    logic              find_reg, find_next;
    logic              found_reg, found_next;
    logic [IW-1:0]     fidx_reg, fidx_next;
    logic [DATA_W-1:0] key_reg, key_next;
    logic [DATA_W-1:0] rval_reg, rval_next;
    rsp_t              rsp_reg, rsp_next;
    logic              rsp_valid_reg, rsp_valid_next;

    cell_ctrl_t        ctrl;
    logic [IW-1:0]     cell_pos;
    logic [DATA_W-1:0] head;

    logic              out_free;
    logic              accept;
    logic [PW-1:0]     pos_big;
    logic [PW-1:0]     cnt_big;
    logic              pos_ok;
    logic              full;
    logic              empty;
    logic              k_live;
    logic              k_back;

    sal_cell_row #(
        .CAPACITY (CAPACITY),
        .IW       (IW)
    ) u_row (
        .clk  (clk),
        .ctrl (ctrl),
        .pos  (cell_pos),
        .head (head)
    );

    assign out_free  = !rsp_valid_reg || rsp_ready;
    assign req_ready = (state_reg == S_IDLE) && out_free;
    assign accept    = req_valid && req_ready;

    assign pos_big = PW'(req.position);
    assign cnt_big = PW'(count_reg);
    assign pos_ok  = pos_big < cnt_big;
    assign full    = count_reg == CAP_CNT;
    assign empty   = count_reg == '0;
    assign k_live  = CW'(k_reg) < count_reg;
    assign k_back  = CW'(k_reg) == (count_reg - CW'(1));

    // Decode, scan sequencing and response build
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        k_next         = k_reg;
        find_next      = find_reg;
        found_next     = found_reg;
        fidx_next      = fidx_reg;
        key_next       = key_reg;
        rval_next      = rval_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        ctrl.mode      = CM_HOLD;
        ctrl.data      = req.data_value;
        cell_pos       = pos_big[IW-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    rsp_next.status      = ST_OK;
                    rsp_next.found_index = '0;
                    rsp_next.read_value  = '0;
                    rsp_valid_next       = 1'b1;
                    unique case (req.op)
                        OP_INSERT:
                        begin
                            if (!pos_ok)
                                rsp_next.status = ST_RANGE;
                            else if (full)
                                rsp_next.status = ST_FULL;
                            else
                            begin
                                ctrl.mode  = CM_SHIFT_UP;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        OP_REPLACE:
                        begin
                            if (!pos_ok)
                                rsp_next.status = ST_RANGE;
                            else
                                ctrl.mode = CM_WRITE;
                        end
                        OP_REMOVE:
                        begin
                            if (!pos_ok)
                                rsp_next.status = ST_RANGE;
                            else
                            begin
                                ctrl.mode  = CM_SHIFT_DOWN;
                                count_next = count_reg - CW'(1);
                            end
                        end
                        OP_PUSH_FRONT:
                        begin
                            if (full)
                                rsp_next.status = ST_FULL;
                            else
                            begin
                                ctrl.mode  = CM_SHIFT_UP;
                                cell_pos   = '0;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        OP_PUSH_BACK:
                        begin
                            if (full)
                                rsp_next.status = ST_FULL;
                            else
                            begin
                                ctrl.mode  = CM_WRITE;
                                cell_pos   = count_reg[IW-1:0];
                                count_next = count_reg + CW'(1);
                            end
                        end
                        OP_POP_FRONT:
                        begin
                            if (empty)
                                rsp_next.status = ST_EMPTY;
                            else
                            begin
                                ctrl.mode  = CM_SHIFT_DOWN;
                                cell_pos   = '0;
                                count_next = count_reg - CW'(1);
                            end
                        end
                        OP_POP_BACK:
                        begin
                            if (empty)
                                rsp_next.status = ST_EMPTY;
                            else
                                count_next = count_reg - CW'(1);
                        end
                        OP_FIND:
                        begin
                            if (empty)
                                rsp_next.status = ST_NOTFOUND;
                            else
                            begin
                                rsp_valid_next = rsp_valid_reg && !rsp_ready;
                                state_next     = S_SCAN;
                                find_next      = 1'b1;
                            end
                        end
                        OP_READ_FRONT:
                        begin
                            if (empty)
                                rsp_next.status = ST_EMPTY;
                            else
                                rsp_next.read_value = head;
                        end
                        OP_READ_BACK:
                        begin
                            if (empty)
                                rsp_next.status = ST_EMPTY;
                            else
                            begin
                                rsp_valid_next = rsp_valid_reg && !rsp_ready;
                                state_next     = S_SCAN;
                                find_next      = 1'b0;
                            end
                        end
                        OP_CLEAR:
                        begin
                            count_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                    rsp_next.element_count = COUNT_OUT_W'(OW'(count_next));
                    // Scan setup; only used when a scan starts
                    k_next     = '0;
                    found_next = 1'b0;
                    fidx_next  = '0;
                    key_next   = req.data_value;
                    rval_next  = '0;
                end
            end
            S_SCAN:
            begin
                // Rotate one place; cell 0 shows element k this cycle
                ctrl.mode = CM_SHIFT_DOWN;
                cell_pos  = '0;
                if (find_reg && !found_reg && k_live && (head == key_reg))
                begin
                    found_next = 1'b1;
                    fidx_next  = k_reg;
                end
                if (!find_reg && k_back)
                    rval_next = head;
                k_next = k_reg + IW'(1);
                if (k_reg == LAST_IDX)
                begin
                    k_next     = '0;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    rsp_next.found_index   = '0;
                    rsp_next.read_value    = '0;
                    rsp_next.status        = ST_OK;
                    rsp_next.element_count = COUNT_OUT_W'(OW'(count_reg));
                    if (find_reg)
                    begin
                        if (found_reg)
                            rsp_next.found_index = POS_W'(FW'(fidx_reg));
                        else
                            rsp_next.status = ST_NOTFOUND;
                    end
                    else
                        rsp_next.read_value = rval_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            k_reg         <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            k_reg         <= k_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload and scan bookkeeping
    always_ff @(posedge clk)
    begin
        find_reg  <= find_next;
        found_reg <= found_next;
        fidx_reg  <= fidx_next;
        key_reg   <= key_next;
        rval_reg  <= rval_next;
        rsp_reg   <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
